// File: rtl/kpl_pkg.sv
// Shared types, codes and reset values for the keypad password lock.
// No dependencies; every other file takes names from here by scope or by import.
package kpl_pkg;

    localparam int MAX_DIGITS_DEF = 6;
    localparam int PASS_SLOTS     = 6;

    localparam int DIGIT_W   = 4;
    localparam int PW_DIG_W  = 24;
    localparam int PW_LEN_W  = 3;
    localparam int TRIES_W   = 4;
    localparam int STATE_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 24;

    localparam logic [STATE_W-1:0] ST_READY  = 3'd0;
    localparam logic [STATE_W-1:0] ST_RESET  = 3'd1;
    localparam logic [STATE_W-1:0] ST_ENTER  = 3'd2;
    localparam logic [STATE_W-1:0] ST_CHECK  = 3'd3;
    localparam logic [STATE_W-1:0] ST_WRONG  = 3'd4;
    localparam logic [STATE_W-1:0] ST_LOCKED = 3'd5;
    localparam logic [STATE_W-1:0] ST_MENU   = 3'd6;

    localparam logic [DIGIT_W-1:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [DIGIT_W-1:0] KEY_A         = 4'd10;
    localparam logic [DIGIT_W-1:0] KEY_B         = 4'd11;
    localparam logic [DIGIT_W-1:0] KEY_C         = 4'd12;
    localparam logic [DIGIT_W-1:0] KEY_E         = 4'd14;
    localparam logic [DIGIT_W-1:0] MASK_SYMBOL   = 4'd10;

    localparam logic [CFG_IDX_W-1:0] REG_PW_DIGITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PW_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIES_LIMIT = 2'd2;

    localparam logic [PW_DIG_W-1:0] PW_DIGITS_RST   = 24'd0;
    localparam logic [PW_LEN_W-1:0] PW_LENGTH_RST   = 3'd4;
    localparam logic [TRIES_W-1:0]  TRIES_LIMIT_RST = 4'd3;
    localparam logic [PW_LEN_W-1:0] PW_LENGTH_MAX   = 3'd6;

    typedef struct packed {
        logic [PW_DIG_W-1:0] password_digits;
        logic [PW_LEN_W-1:0] password_length;
        logic [TRIES_W-1:0]  tries_limit;
    } cfg_t;

    typedef struct packed {
        logic [STATE_W-1:0] fsm_state;
        logic               echo_valid;
        logic [DIGIT_W-1:0] echo_symbol;
        logic               show_digits;
        logic [2:0]         entered_count;
        logic [TRIES_W-1:0] tries_remaining;
        logic               green_led;
        logic               red_led;
        logic               buzzer_pulse;
    } result_t;

endpackage

// File: rtl/kpl_cfg_regs.sv
// Configuration register file of the keypad password lock.
// Depends on kpl_pkg for register indexes, reset values and cfg_t.
module kpl_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [kpl_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [kpl_pkg::CFG_DAT_W-1:0] wr_data,
    output kpl_pkg::cfg_t                 cfg
);

    kpl_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.password_digits <= kpl_pkg::PW_DIGITS_RST;
            cfg_reg.password_length <= kpl_pkg::PW_LENGTH_RST;
            cfg_reg.tries_limit     <= kpl_pkg::TRIES_LIMIT_RST;
        end else if (wr_en) begin
            case (wr_index)
                kpl_pkg::REG_PW_DIGITS: begin
                    cfg_reg.password_digits <= wr_data[kpl_pkg::PW_DIG_W-1:0];
                end
                kpl_pkg::REG_PW_LENGTH: begin
                    cfg_reg.password_length <= wr_data[kpl_pkg::PW_LEN_W-1:0];
                end
                kpl_pkg::REG_TRIES_LIMIT: begin
                    cfg_reg.tries_limit <= wr_data[kpl_pkg::TRIES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/kpl_fsm.sv
// Lock state machine: state, entered digits, counters, and the result of one step.
// Depends on kpl_pkg for state and key codes, cfg_t and result_t.
module kpl_fsm #(
    parameter int MAX_DIGITS = kpl_pkg::MAX_DIGITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step_en,
    input  logic                        key_present,
    input  logic [kpl_pkg::DIGIT_W-1:0] key_code,
    input  kpl_pkg::cfg_t               cfg,
    output kpl_pkg::result_t            result
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int CMP_W = (CNT_W > kpl_pkg::PW_LEN_W) ? CNT_W : kpl_pkg::PW_LEN_W;
    localparam int NSLOT = (MAX_DIGITS < kpl_pkg::PASS_SLOTS) ? MAX_DIGITS
                                                              : kpl_pkg::PASS_SLOTS;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_DIGITS);

    logic [kpl_pkg::STATE_W-1:0] state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [kpl_pkg::TRIES_W-1:0] tries_reg, tries_next;
    logic                        show_reg, show_next;
    logic                        green_reg, green_next;
    logic                        red_reg, red_next;
    logic [kpl_pkg::DIGIT_W-1:0] digits_reg [MAX_DIGITS];

    logic                        digit_we;
    logic                        echo_valid;
    logic [kpl_pkg::DIGIT_W-1:0] echo_symbol;
    logic                        buzz;
    logic                        entry_match;

    always_comb begin
        logic ok;
        ok = (cfg.password_length <= kpl_pkg::PW_LENGTH_MAX) &&
             (CMP_W'(count_reg) == CMP_W'(cfg.password_length));
        for (int i = 0; i < NSLOT; i++) begin
            if ((CNT_W'(i) < count_reg) &&
                (digits_reg[i] != cfg.password_digits[4*i +: kpl_pkg::DIGIT_W])) begin
                ok = 1'b0;
            end
        end
        entry_match = ok;
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        tries_next  = tries_reg;
        show_next   = show_reg;
        green_next  = green_reg;
        red_next    = red_reg;
        digit_we    = 1'b0;
        echo_valid  = 1'b0;
        echo_symbol = '0;
        buzz        = 1'b0;
        case (state_reg)
            kpl_pkg::ST_READY: begin
                state_next = kpl_pkg::ST_RESET;
            end
            kpl_pkg::ST_RESET: begin
                count_next = '0;
                show_next  = 1'b0;
                state_next = kpl_pkg::ST_ENTER;
            end
            kpl_pkg::ST_ENTER: begin
                if (key_present) begin
                    if (key_code inside {[4'd0:kpl_pkg::KEY_DIGIT_MAX]}) begin
                        if (count_reg < CNT_FULL) begin
                            digit_we    = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                            echo_valid  = 1'b1;
                            echo_symbol = show_reg ? key_code : kpl_pkg::MASK_SYMBOL;
                        end
                    end else if (key_code == kpl_pkg::KEY_A) begin
                        show_next = ~show_reg;
                    end else if (key_code == kpl_pkg::KEY_E) begin
                        state_next = kpl_pkg::ST_CHECK;
                    end
                end
            end
            kpl_pkg::ST_CHECK: begin
                if (entry_match) begin
                    green_next = 1'b1;
                    red_next   = 1'b0;
                    tries_next = cfg.tries_limit;
                    state_next = kpl_pkg::ST_MENU;
                end else begin
                    if (tries_reg != '0) begin
                        tries_next = tries_reg - kpl_pkg::TRIES_W'(1);
                    end
                    state_next = kpl_pkg::ST_WRONG;
                end
            end
            kpl_pkg::ST_WRONG: begin
                state_next = (tries_reg != '0) ? kpl_pkg::ST_RESET : kpl_pkg::ST_LOCKED;
            end
            kpl_pkg::ST_LOCKED: begin
                red_next   = 1'b1;
                green_next = 1'b0;
                buzz       = 1'b1;
                if (key_present && (key_code == kpl_pkg::KEY_C)) begin
                    red_next   = 1'b0;
                    tries_next = cfg.tries_limit;
                    state_next = kpl_pkg::ST_READY;
                end
            end
            kpl_pkg::ST_MENU: begin
                if (key_present && (key_code == kpl_pkg::KEY_B)) begin
                    green_next = 1'b0;
                    state_next = kpl_pkg::ST_RESET;
                end
            end
            default: begin
                state_next = kpl_pkg::ST_READY;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kpl_pkg::ST_READY;
            count_reg <= '0;
            tries_reg <= kpl_pkg::TRIES_LIMIT_RST;
            show_reg  <= 1'b0;
            green_reg <= 1'b0;
            red_reg   <= 1'b0;
        end else if (step_en) begin
            state_reg <= state_next;
            count_reg <= count_next;
            tries_reg <= tries_next;
            show_reg  <= show_next;
            green_reg <= green_next;
            red_reg   <= red_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (step_en && digit_we && (count_reg == CNT_W'(i))) begin
                digits_reg[i] <= key_code;
            end
        end
    end

    always_comb begin
        result.fsm_state       = state_next;
        result.echo_valid      = echo_valid;
        result.echo_symbol     = echo_symbol;
        result.show_digits     = show_next;
        result.entered_count   = 3'(count_next);
        result.tries_remaining = tries_next;
        result.green_led       = green_next;
        result.red_led         = red_next;
        result.buzzer_pulse    = buzz;
    end

endmodule

// File: rtl/keypad_password_lock_fsm.sv
// Keypad password lock: one keypad scan per item, one result item per scan. An accepted
// item is held in an input register, steps the lock state machine and lands in an output
// register, from which its result is offered; a new item is taken every cycle, and only a
// stalled result queue (m_tready low) slows intake. Configuration writes complete in the
// cycle they are offered. Depends on kpl_pkg, kpl_cfg_regs, kpl_fsm.
module keypad_password_lock_fsm #(
    parameter int MAX_DIGITS = kpl_pkg::MAX_DIGITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [kpl_pkg::S_DATA_W-1:0]   s_tdata,   // [3:0] key_code, rest zero
    input  logic                           s_tuser,   // [0] key_present
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] fsm_state, [6:3] echo_symbol, [7] show_digits, [10:8] entered_count,
    // [14:11] tries_remaining, [15] green_led, [16] red_led, [17] buzzer_pulse, rest zero
    output logic [kpl_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tuser,   // [0] echo_valid
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kpl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kpl_pkg::CFG_DAT_W-1:0]  cfg_data
);

    kpl_pkg::cfg_t    cfg;
    kpl_pkg::result_t step_result;
    kpl_pkg::result_t out_reg;

    logic                        in_valid_reg;
    logic                        in_present_reg;
    logic [kpl_pkg::DIGIT_W-1:0] in_key_reg;
    logic                        m_valid_reg;
    logic                        advance;

    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_present_reg <= s_tuser;
            in_key_reg     <= s_tdata[kpl_pkg::DIGIT_W-1:0];
        end
    end

    kpl_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    kpl_fsm #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .key_present (in_present_reg),
        .key_code    (in_key_reg),
        .cfg         (cfg),
        .result      (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.echo_valid;
    assign m_tdata  = {6'd0,
                       out_reg.buzzer_pulse,
                       out_reg.red_led,
                       out_reg.green_led,
                       out_reg.tries_remaining,
                       out_reg.entered_count,
                       out_reg.show_digits,
                       out_reg.echo_symbol,
                       out_reg.fsm_state};

endmodule

// File: rtl/kpl_checker.sv
// Port-level checks on the keypad password lock's result stream, bound to the top level.
// Depends on kpl_pkg for state codes and on keypad_password_lock_fsm port names.
module kpl_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [kpl_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tuser
);

    logic [kpl_pkg::STATE_W-1:0] st;
    assign st = m_tdata[2:0];

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result item changed");

    a_leds_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[15] && m_tdata[16]))
        else $error("green and red indicators both on");

    a_echo_in_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> st == kpl_pkg::ST_ENTER)
        else $error("digit echo outside entry state");

    a_buzz_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17] |-> (st == kpl_pkg::ST_LOCKED || st == kpl_pkg::ST_READY))
        else $error("buzzer pulse after a step that was not locked");

endmodule

bind keypad_password_lock_fsm kpl_checker u_kpl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/sv/keypad_password_lock_fsm_chk.sv
// Checker for the keypad password lock: watches the scan, result and register channels,
// keeps its own model of the lock and compares every result item field by field.
// Depends on kpl_pkg for widths, state and key codes, register indexes and result_t.
`timescale 1ns / 1ps

module keypad_password_lock_fsm_chk (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [kpl_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [kpl_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          m_tuser,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [kpl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kpl_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                            mismatches,
    output int                            pending
);
    import kpl_pkg::*;

    logic [PW_DIG_W-1:0] pw_digits;
    logic [PW_LEN_W-1:0] pw_len;
    logic [TRIES_W-1:0]  tries_reload;

    logic [STATE_W-1:0]  lock_st;
    logic [DIGIT_W-1:0]  typed_digits [MAX_DIGITS_DEF];
    logic [2:0]          digit_cnt;
    logic [TRIES_W-1:0]  tries_left;
    logic                show_on;
    logic                green_on;
    logic                red_on;

    result_t             awaited_status [$];

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic result_t advance_lock(input logic pres, input logic [DIGIT_W-1:0] key);
        result_t r;
        logic    matched;
        int      i;
        r = '0;
        case (lock_st)
            ST_READY: lock_st = ST_RESET;
            ST_RESET: begin
                digit_cnt = '0;
                show_on   = 1'b0;
                lock_st   = ST_ENTER;
            end
            ST_ENTER: begin
                if (pres) begin
                    if (key <= KEY_DIGIT_MAX) begin
                        if (digit_cnt < MAX_DIGITS_DEF) begin
                            typed_digits[digit_cnt] = key;
                            digit_cnt     = digit_cnt + 3'd1;
                            r.echo_valid  = 1'b1;
                            r.echo_symbol = show_on ? key : MASK_SYMBOL;
                        end
                    end else if (key == KEY_A) begin
                        show_on = ~show_on;
                    end else if (key == KEY_E) begin
                        lock_st = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                matched = (pw_len <= PASS_SLOTS) && (digit_cnt == pw_len);
                for (i = 0; i < digit_cnt; i++) begin
                    if (typed_digits[i] != pw_digits[4*i +: 4])
                        matched = 1'b0;
                end
                if (matched) begin
                    green_on   = 1'b1;
                    red_on     = 1'b0;
                    tries_left = tries_reload;
                    lock_st    = ST_MENU;
                end else begin
                    if (tries_left > 0)
                        tries_left = tries_left - 4'd1;
                    lock_st = ST_WRONG;
                end
            end
            ST_WRONG: lock_st = (tries_left > 0) ? ST_RESET : ST_LOCKED;
            ST_LOCKED: begin
                red_on         = 1'b1;
                green_on       = 1'b0;
                r.buzzer_pulse = 1'b1;
                if (pres && key == KEY_C) begin
                    red_on     = 1'b0;
                    tries_left = tries_reload;
                    lock_st    = ST_READY;
                end
            end
            ST_MENU: begin
                if (pres && key == KEY_B) begin
                    green_on = 1'b0;
                    lock_st  = ST_RESET;
                end
            end
            default: lock_st = ST_READY;
        endcase
        r.fsm_state       = lock_st;
        r.show_digits     = show_on;
        r.entered_count   = digit_cnt;
        r.tries_remaining = tries_left;
        r.green_led       = green_on;
        r.red_led         = red_on;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $realtime, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            pw_digits    = PW_DIGITS_RST;
            pw_len       = PW_LENGTH_RST;
            tries_reload = TRIES_LIMIT_RST;
            lock_st      = ST_READY;
            digit_cnt    = '0;
            tries_left   = TRIES_LIMIT_RST;
            show_on      = 1'b0;
            green_on     = 1'b0;
            red_on       = 1'b0;
            awaited_status.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_status.size() == 0) begin
                    $display("%0t: result item with none expected, actual %h", $realtime,
                             m_tdata);
                    mismatches++;
                end else begin
                    want = awaited_status.pop_front();
                    check_field("fsm_state", int'(want.fsm_state), int'(m_tdata[2:0]));
                    check_field("echo_valid", int'(want.echo_valid), int'(m_tuser));
                    check_field("echo_symbol", int'(want.echo_symbol), int'(m_tdata[6:3]));
                    check_field("show_digits", int'(want.show_digits), int'(m_tdata[7]));
                    check_field("entered_count", int'(want.entered_count),
                                int'(m_tdata[10:8]));
                    check_field("tries_remaining", int'(want.tries_remaining),
                                int'(m_tdata[14:11]));
                    check_field("green_led", int'(want.green_led), int'(m_tdata[15]));
                    check_field("red_led", int'(want.red_led), int'(m_tdata[16]));
                    check_field("buzzer_pulse", int'(want.buzzer_pulse), int'(m_tdata[17]));
                    check_field("padding", 0, int'(m_tdata[M_DATA_W-1:18]));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PW_DIGITS:   pw_digits    = cfg_data[PW_DIG_W-1:0];
                    REG_PW_LENGTH:   pw_len       = cfg_data[PW_LEN_W-1:0];
                    REG_TRIES_LIMIT: tries_reload = cfg_data[TRIES_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                awaited_status.push_back(advance_lock(s_tuser, s_tdata[DIGIT_W-1:0]));
        end
        pending = awaited_status.size();
    end

endmodule

// File: tb/sv/keypad_password_lock_fsm_tb.sv
// Top of the keypad password lock testbench: clock, reset, scan and register stimulus
// with random backpressure, and the final verdict.
// Depends on kpl_pkg, keypad_password_lock_fsm and keypad_password_lock_fsm_chk.
`timescale 1ns / 1ps

module keypad_password_lock_fsm_tb;
    import kpl_pkg::*;

    localparam int                   LIMIT_CYCLES = 400000;
    localparam int                   HOLD_CYCLES  = 300;
    localparam int                   KEYS_TOTAL   = 1450;
    localparam int                   PHASES       = 6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
    localparam logic [DIGIT_W-1:0]   KEY_D        = 4'd13;
    localparam logic [DIGIT_W-1:0]   KEY_F        = 4'd15;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    int                   mismatches;
    int                   pending;

    int                   send_idle = 0;
    int                   recv_idle = 0;
    logic                 hold_req  = 1'b0;
    int                   keys_sent = 0;
    logic [PW_DIG_W-1:0]  pw_digits_tb = PW_DIGITS_RST;
    logic [PW_LEN_W-1:0]  pw_len_tb    = PW_LENGTH_RST;

    always #5 aclk = ~aclk;

    keypad_password_lock_fsm i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    keypad_password_lock_fsm_chk i_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_tready = ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_scan(input logic pres, input logic [DIGIT_W-1:0] code);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = pres;
        s_tdata  = {{(S_DATA_W-DIGIT_W){1'b0}}, code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        keys_sent++;
        @(negedge aclk);
    endtask

    task automatic idle_scan();
        case ($urandom_range(0, 3))
            0:       send_scan(1'b1, KEY_D);
            1:       send_scan(1'b1, KEY_F);
            default: send_scan(1'b0, DIGIT_W'($urandom_range(0, 15)));
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_setting(input logic [PW_DIG_W-1:0] digits,
                                 input logic [PW_LEN_W-1:0] len,
                                 input logic [TRIES_W-1:0]  tries);
        write_reg(REG_PW_DIGITS, digits);
        write_reg(REG_PW_LENGTH, CFG_DAT_W'(len));
        write_reg(REG_TRIES_LIMIT, CFG_DAT_W'(tries));
        pw_digits_tb = digits;
        pw_len_tb    = len;
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [PW_DIG_W-1:0] random_password();
        logic [PW_DIG_W-1:0] p;
        int                  i;
        for (i = 0; i < PASS_SLOTS; i++)
            p[4*i +: 4] = DIGIT_W'($urandom_range(0, 9));
        return p;
    endfunction

    task automatic run_sessions(input int target);
        int kind;
        int n;
        int i;
        while (keys_sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                idle_scan();
                idle_scan();
                if ($urandom_range(0, 3) == 0)
                    send_scan(1'b1, KEY_A);
                n = (pw_len_tb > PASS_SLOTS) ? PASS_SLOTS : pw_len_tb;
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(0, 5) == 0)
                        send_scan(1'b0, DIGIT_W'($urandom_range(0, 15)));
                    send_scan(1'b1, pw_digits_tb[4*i +: 4]);
                end
                send_scan(1'b1, KEY_E);
                send_scan(1'($urandom_range(0, 1)), DIGIT_W'($urandom_range(0, 15)));
                repeat ($urandom_range(0, 3))
                    send_scan(1'($urandom_range(0, 1)), DIGIT_W'($urandom_range(0, 15)));
                send_scan(1'b1, KEY_B);
            end else if (kind < 65) begin
                idle_scan();
                idle_scan();
                n = $urandom_range(0, 7);
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(0, 4) == 0)
                        send_scan(1'b1, KEY_A);
                    send_scan(1'b1, DIGIT_W'($urandom_range(0, 9)));
                end
                send_scan(1'b1, KEY_E);
                idle_scan();
                idle_scan();
                if ($urandom_range(0, 9) < 3)
                    send_scan(1'b1, KEY_C);
            end else if (kind < 75) begin
                send_scan(1'b1, KEY_C);
                idle_scan();
            end else begin
                repeat ($urandom_range(1, 6))
                    send_scan(1'($urandom_range(0, 1)), DIGIT_W'($urandom_range(0, 15)));
            end
        end
    endtask

    initial begin
        int ph;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        send_idle = 11;
        recv_idle = 72;
        send_scan(1'b1, KEY_E);
        send_scan(1'b1, KEY_C);
        send_scan(1'b1, KEY_A);
        send_scan(1'b1, 4'd0);
        send_scan(1'b1, KEY_DIGIT_MAX);
        send_scan(1'b0, KEY_E);
        send_scan(1'b1, KEY_F);
        send_scan(1'b1, KEY_D);
        send_scan(1'b1, KEY_E);
        send_scan(1'b1, KEY_B);
        send_scan(1'b1, 4'd5);
        send_scan(1'b1, 4'd0);
        repeat (4) send_scan(1'b1, 4'd0);
        send_scan(1'b1, KEY_E);
        send_scan(1'b1, KEY_B);
        send_scan(1'b1, 4'd1);
        send_scan(1'b1, 4'd2);
        send_scan(1'b1, KEY_B);
        send_scan(1'b0, 4'd0);
        repeat (7) send_scan(1'b1, KEY_DIGIT_MAX);
        send_scan(1'b1, KEY_E);
        idle_scan();
        idle_scan();
        wait_idle();
        write_reg(REG_UNUSED, CFG_DAT_W'($urandom));

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph / 2)
                0: begin
                    send_idle = 11;
                    recv_idle = 72;
                end
                1: begin
                    send_idle = 72;
                    recv_idle = 11;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            wait_idle();
            case (ph)
                0: write_setting(24'h999999, PW_LENGTH_MAX, 4'd15);
                1: write_setting(random_password(), 3'd0, 4'd1);
                2: write_setting(24'hFFFFFF, 3'd3, 4'd0);
                3: write_setting(random_password(), 3'd7, 4'd2);
                4: write_setting(random_password(), PW_LEN_W'($urandom_range(1, 5)),
                                 TRIES_W'($urandom_range(1, 15)));
                default: write_setting(random_password(), PW_LENGTH_MAX,
                                       TRIES_W'($urandom_range(1, 15)));
            endcase
            if (ph == 4)
                hold_req = 1'b1;
            run_sessions(KEYS_TOTAL * (ph + 1) / PHASES);
        end

        wait_idle();
        repeat (10) @(negedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
